### rtl/core/tpss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-class stable priority sorter.
// No dependencies.
package tpss_pkg;

    localparam int unsigned TagW         = 16;
    localparam int unsigned KeyW         = 8;
    localparam int unsigned MaxItemsDef  = 64;
    localparam logic [KeyW-1:0] ThreshRst = 8'd60;

    // queued word between front and back
    typedef struct packed {
        logic [TagW-1:0] tag;
        logic [KeyW-1:0] key;
        logic            prio;
        logic            last;
    } t_item;

endpackage

### rtl/core/tpss_front.sv
`timescale 1ns / 1ps
// Front end: threshold register and classification of incoming words.
// Depends on tpss_pkg.
module tpss_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [7:0]             i_cfg_data,
    input  logic [23:0]            i_data,
    input  logic                   i_last,
    output tpss_pkg::t_item        o_item
);
    import tpss_pkg::*;

    logic [KeyW-1:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= ThreshRst;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    always_comb begin
        o_item.tag  = i_data[TagW-1:0];
        o_item.key  = i_data[TagW+KeyW-1:TagW];
        o_item.prio = (i_data[TagW+KeyW-1:TagW] >= r_thresh);
        o_item.last = i_last;
    end

endmodule

### rtl/core/tpss_fifo.sv
`timescale 1ns / 1ps
// Four-entry queue of classified words between front and back.
// Depends on tpss_pkg.
module tpss_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tpss_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tpss_pkg::t_item o_item
);
    import tpss_pkg::*;

    t_item      r_buf [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 2'd1;
            if (do_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b00, do_push} - {2'b00, do_pop};
        end
    end

endmodule

### rtl/core/tpss_back.sv
`timescale 1ns / 1ps
// Back end: insertion chain for the priority class, arrival-order store for
// the rest, and the drain sequencer with output register. Depends on tpss_pkg.
module tpss_back #(
    parameter int unsigned MAX_ITEMS = tpss_pkg::MaxItemsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tpss_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_tag,
    output logic            o_prio,
    output logic            o_ovf,
    output logic            o_last
);
    import tpss_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned IW = $clog2(MAX_ITEMS);

    localparam logic [1:0] S_COLL = 2'd0;
    localparam logic [1:0] S_DP   = 2'd1;
    localparam logic [1:0] S_NRD  = 2'd2;
    localparam logic [1:0] S_NEM  = 2'd3;

    logic [1:0]      r_state;
    logic [CW-1:0]   r_np, r_nn;
    logic [IW-1:0]   r_rd;
    logic            r_ovfs;
    logic [KeyW-1:0] r_ckey [MAX_ITEMS];
    logic [TagW-1:0] r_ctag [MAX_ITEMS];
    logic [TagW-1:0] r_mem  [MAX_ITEMS];
    logic [TagW-1:0] r_q;
    logic            r_ov, r_oprio, r_oovf, r_olast;
    logic [TagW-1:0] r_otag;

    logic [MAX_ITEMS-1:0] lt;
    logic                 take, full, ins, out_free, dp_last, nm_last, emit;

    assign o_pop    = (r_state == S_COLL);
    assign take     = o_pop && i_valid;
    assign full     = ({1'b0, r_np} + {1'b0, r_nn}) == (CW+1)'(MAX_ITEMS);
    assign ins      = take && !full && i_item.prio;
    assign out_free = !r_ov || i_ready;
    assign dp_last  = (r_np == CW'(1)) && (r_nn == '0);
    assign nm_last  = (CW'(r_rd) + CW'(1)) == r_nn;
    // a result is loaded into the output register this cycle
    assign emit     = out_free && (((r_state == S_DP) && (r_np != '0)) ||
                                   (r_state == S_NEM));

    // cells past the sorted part, or holding a smaller key, move down
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            lt[i] = (CW'(i) >= r_np) || (r_ckey[i] < i_item.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins) begin
            for (int i = 0; i < MAX_ITEMS; i++) begin
                if (lt[i]) begin
                    if (i > 0 && lt[(i > 0) ? i-1 : 0]) begin
                        r_ckey[i] <= r_ckey[(i > 0) ? i-1 : 0];
                        r_ctag[i] <= r_ctag[(i > 0) ? i-1 : 0];
                    end else begin
                        r_ckey[i] <= i_item.key;
                        r_ctag[i] <= i_item.tag;
                    end
                end
            end
        end else if (r_state == S_DP && r_np != '0 && out_free) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                r_ckey[i] <= r_ckey[i+1];
                r_ctag[i] <= r_ctag[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !full && !i_item.prio) begin
            r_mem[r_nn[IW-1:0]] <= i_item.tag;
        end
        r_q <= r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLL;
            r_np    <= '0;
            r_nn    <= '0;
            r_rd    <= '0;
            r_ovfs  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= emit || (r_ov && !i_ready);
            unique case (r_state)
                S_COLL: begin
                    if (take) begin
                        if (full)              r_ovfs <= 1'b1;
                        else if (i_item.prio)  r_np   <= r_np + CW'(1);
                        else                   r_nn   <= r_nn + CW'(1);
                        if (i_item.last)       r_state <= S_DP;
                    end
                end
                S_DP: begin
                    if (r_np == '0) begin
                        r_rd    <= '0;
                        r_state <= S_NRD;
                    end else if (out_free) begin
                        r_otag  <= r_ctag[0];
                        r_oprio <= 1'b1;
                        r_oovf  <= r_ovfs;
                        r_olast <= dp_last;
                        r_np    <= r_np - CW'(1);
                        if (dp_last) begin
                            r_ovfs  <= 1'b0;
                            r_state <= S_COLL;
                        end
                    end
                end
                S_NRD: r_state <= S_NEM;
                S_NEM: begin
                    if (out_free) begin
                        r_otag  <= r_q;
                        r_oprio <= 1'b0;
                        r_oovf  <= r_ovfs;
                        r_olast <= nm_last;
                        if (nm_last) begin
                            r_nn    <= '0;
                            r_ovfs  <= 1'b0;
                            r_state <= S_COLL;
                        end else begin
                            r_rd    <= r_rd + IW'(1);
                            r_state <= S_NRD;
                        end
                    end
                end
                default: r_state <= S_COLL;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_tag   = r_otag;
    assign o_prio  = r_oprio;
    assign o_ovf   = r_oovf;
    assign o_last  = r_olast;

endmodule

### rtl/core/threshold_priority_stable_sorter.sv
`timescale 1ns / 1ps
// Each input word is classified on entry against the threshold and queued; the back
// end takes one word a cycle while collecting, placing priority items into a sorted
// insertion chain (key high to low, ties in arrival order) and the rest into an
// arrival-order store. After the word marked tlast, the block emits the priority class,
// one result a cycle unless the output stalls, then each other item by a store read
// and an emit. Input words are still taken into the four-word queue while a batch
// drains. Top level. Depends on tpss_pkg, tpss_front, tpss_fifo, tpss_back.
module threshold_priority_stable_sorter #(
    parameter int unsigned MAX_ITEMS = tpss_pkg::MaxItemsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // priority_threshold
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // item_tag[15:0], sort_key[23:16]
    input  logic        s_axis_tlast,   // batch_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_tag[15:0], is_priority[16],
                                        // batch_overflow[17], zeros
    output logic        m_axis_tlast    // final_result
);
    import tpss_pkg::*;

    t_item           w_fitem, w_qitem;
    logic            w_full, w_qvalid, w_pop;
    logic [TagW-1:0] w_tag;
    logic            w_prio, w_ovf;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_full;

    tpss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_data      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_item      (w_fitem)
    );

    tpss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_item  (w_qitem)
    );

    tpss_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_item  (w_qitem),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tag   (w_tag),
        .o_prio  (w_prio),
        .o_ovf   (w_ovf),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_ovf, w_prio, w_tag};

endmodule
